>>> rtl/core/iordt_pkg.sv
// shared types, codes and constants of the i/o range decoder table
package iordt_pkg;

	localparam int TABLE_SLOTS_DEF = 16;
	localparam int ADDR_BITS_DEF   = 16;
	localparam int FIELD_W         = 16;
	localparam int SLOT_W          = 4;

	// command codes
	localparam logic [1:0] CMD_MAP   = 2'd0;
	localparam logic [1:0] CMD_UNMAP = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_WRITE = 2'd3;

	// status codes
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_OVERLAP = 2'd1;
	localparam logic [1:0] STS_FULL    = 2'd2;
	localparam logic [1:0] STS_NODEV   = 2'd3;

	localparam logic [1:0]         WIDTH_WORD = 2'd2;
	localparam logic [FIELD_W-1:0] FILL_BYTE  = 16'h00FF;
	localparam logic [FIELD_W-1:0] FILL_WORD  = 16'hFFFF;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [FIELD_W-1:0] port_addr;
		logic [FIELD_W-1:0] range_end;
		logic [FIELD_W-1:0] write_value;
		logic [1:0]         access_width;
		logic [31:0]        release_id;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        mapping_id;
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic [FIELD_W-1:0] fwd_addr;
		logic [FIELD_W-1:0] fwd_value;
		logic [1:0]         fwd_width;
		logic               fwd_is_write;
		logic [FIELD_W-1:0] fill_value;
		logic               error_seen;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

>>> rtl/core/iordt_table_mem.sv
// range table storage: one write port, one registered read port
module iordt_table_mem #(
	parameter int DEPTH = iordt_pkg::TABLE_SLOTS_DEF,
	parameter int WIDTH = 2 * iordt_pkg::ADDR_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/io_range_decoder_table_unit.sv
// top level of the i/o range decoder table: scan controller and result register
//
// usage
// - req channel (req_valid / req_stall / req): one command word per item,
//   map a range, unmap an id, or a read / write access to look up
// - rsp channel (rsp_valid / rsp_stall / rsp): exactly one result word per item
// - an item is taken only while the unit is idle; it then reads the table
//   memory one slot per cycle through the single read port up to the
//   high-water mark, and the result is loaded into the output register
//   in the final cycle
// - unmap frees matching slots during the scan (write-back trails the read
//   by one slot, so the two never touch the same entry); a map writes its
//   slot in the final cycle, before the next item can issue a read
// - a finished result sits in the output register; a new item is taken
//   while it waits, and the next result holds in the final cycle until the
//   register frees up
// - reset clears the high-water mark, the sticky error flag and the
//   handshake state; table entries need no clearing since only slots below
//   the high-water mark are ever read
module io_range_decoder_table_unit #(
	parameter int TABLE_SLOTS = iordt_pkg::TABLE_SLOTS_DEF,
	parameter int ADDR_BITS   = iordt_pkg::ADDR_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  iordt_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output iordt_pkg::rsp_t  rsp
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam int ENT_W = 2 * ADDR_BITS;

	iordt_pkg::state_t state_q, state_d;

	// held command word
	iordt_pkg::req_t req_q;

	// scan control
	logic [CNT_W-1:0] scan_idx_q;
	logic [CNT_W-1:0] used_q, used_d;
	logic             err_q, err_d;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	// scan findings
	logic             ovl_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;

	// output register
	logic            rsp_valid_q;
	iordt_pkg::rsp_t rsp_q, rsp_d;
	logic            rsp_load;

	// memory ports
	logic             issue;
	logic [IDX_W-1:0] rd_addr;
	logic [ENT_W-1:0] rd_data;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic             scan_we;
	logic             map_we;
	logic [IDX_W-1:0] map_idx;

	// masked request fields and entry decode
	logic [ADDR_BITS-1:0] addr_m, rend_m;
	logic [ADDR_BITS-1:0] ent_start, ent_end;
	logic [31:0]          ent_id, new_id;
	logic                 ent_live;

	assign addr_m    = req_q.port_addr[ADDR_BITS-1:0];
	assign rend_m    = req_q.range_end[ADDR_BITS-1:0];
	assign new_id    = {16'(rend_m), 16'(addr_m)};
	assign ent_start = rd_data[ADDR_BITS-1:0];
	assign ent_end   = rd_data[ENT_W-1:ADDR_BITS];
	// the id is rebuilt from the stored range; a freed slot holds 0..0
	assign ent_id    = {16'(ent_end), 16'(ent_start)};
	assign ent_live  = (ent_id != 32'd0);

	assign issue   = (state_q == iordt_pkg::ST_SCAN) && (scan_idx_q < used_q);
	assign rd_addr = scan_idx_q[IDX_W-1:0];

	assign req_stall = (state_q != iordt_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	iordt_table_mem #(
		.DEPTH (TABLE_SLOTS),
		.WIDTH (ENT_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iordt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory write selection
	always_comb begin
		state_d  = state_q;
		scan_we  = 1'b0;
		rsp_load = 1'b0;
		unique case (state_q)
			iordt_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = iordt_pkg::ST_SCAN;
				end
			end
			iordt_pkg::ST_SCAN: begin
				// unmap write-back one slot behind the read
				if (vld_s1 && req_q.cmd == iordt_pkg::CMD_UNMAP
						&& ent_id == req_q.release_id) begin
					scan_we = 1'b1;
				end
				if (!issue) begin
					state_d = iordt_pkg::ST_FINISH;
				end
			end
			iordt_pkg::ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = iordt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = iordt_pkg::ST_IDLE;
			end
		endcase
	end

	assign mem_we    = scan_we || (rsp_load && map_we);
	assign mem_waddr = scan_we ? idx_s1 : map_idx;
	assign mem_wdata = scan_we ? '0 : {rend_m, addr_m};

	// result word from the scan findings
	always_comb begin
		rsp_d   = '0;
		err_d   = err_q;
		used_d  = used_q;
		map_we  = 1'b0;
		map_idx = free_idx_q;
		case (req_q.cmd) inside
			iordt_pkg::CMD_MAP: begin
				if (ovl_q) begin
					rsp_d.status = iordt_pkg::STS_OVERLAP;
					err_d        = 1'b1;
				end else if (free_q) begin
					// lowest freed slot below the high-water mark
					map_we  = 1'b1;
					map_idx = free_idx_q;
				end else if (used_q < CNT_W'(TABLE_SLOTS)) begin
					// append at the high-water mark
					map_we  = 1'b1;
					map_idx = used_q[IDX_W-1:0];
					used_d  = CNT_W'(used_q + 1'b1);
				end else begin
					rsp_d.status = iordt_pkg::STS_FULL;
					err_d        = 1'b1;
				end
				if (map_we) begin
					rsp_d.mapping_id = new_id;
					rsp_d.slot       = iordt_pkg::SLOT_W'(map_idx);
				end
			end
			iordt_pkg::CMD_UNMAP: begin
				rsp_d.status = iordt_pkg::STS_OK;
			end
			iordt_pkg::CMD_READ, iordt_pkg::CMD_WRITE: begin
				rsp_d.fwd_addr     = iordt_pkg::FIELD_W'(addr_m);
				rsp_d.fwd_width    = req_q.access_width;
				rsp_d.fwd_is_write = (req_q.cmd == iordt_pkg::CMD_WRITE);
				if (req_q.cmd == iordt_pkg::CMD_WRITE) begin
					rsp_d.fwd_value = req_q.write_value;
				end
				if (hit_q) begin
					rsp_d.hit  = 1'b1;
					rsp_d.slot = iordt_pkg::SLOT_W'(hit_idx_q);
				end else begin
					rsp_d.status = iordt_pkg::STS_NODEV;
					err_d        = 1'b1;
					if (req_q.cmd == iordt_pkg::CMD_READ) begin
						rsp_d.fill_value = (req_q.access_width == iordt_pkg::WIDTH_WORD)
							? iordt_pkg::FILL_WORD : iordt_pkg::FILL_BYTE;
					end
				end
			end
			default: begin
				rsp_d.status = iordt_pkg::STS_OK;
			end
		endcase
		rsp_d.error_seen = err_d;
	end

	// control registers and scan flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			used_q      <= '0;
			err_q       <= 1'b0;
			vld_s1      <= 1'b0;
			ovl_q       <= 1'b0;
			free_q      <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == iordt_pkg::ST_IDLE && req_valid) begin
				scan_idx_q <= '0;
				vld_s1     <= 1'b0;
				ovl_q      <= 1'b0;
				free_q     <= 1'b0;
				hit_q      <= 1'b0;
			end else if (state_q == iordt_pkg::ST_SCAN) begin
				vld_s1 <= issue;
				if (issue) begin
					scan_idx_q <= CNT_W'(scan_idx_q + 1'b1);
				end
				if (vld_s1) begin
					if (ent_live && ent_start <= rend_m && addr_m <= ent_end) begin
						ovl_q <= 1'b1;
					end
					if (!ent_live) begin
						free_q <= 1'b1;
					end
					if (ent_live && ent_start <= addr_m && addr_m <= ent_end) begin
						hit_q <= 1'b1;
					end
				end
			end
			if (rsp_load) begin
				used_q      <= used_d;
				err_q       <= err_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == iordt_pkg::ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (issue) begin
			idx_s1 <= rd_addr;
		end
		if (state_q == iordt_pkg::ST_SCAN && vld_s1) begin
			// first free slot wins, last hit wins
			if (!ent_live && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (ent_live && ent_start <= addr_m && addr_m <= ent_end) begin
				hit_idx_q <= idx_s1;
			end
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_SLOTS))
		else $error("high-water mark beyond table size");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("sticky error flag cleared");

	a_scan_write_unmap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == iordt_pkg::ST_SCAN) |-> req_q.cmd == iordt_pkg::CMD_UNMAP)
		else $error("table write during scan of a non-unmap command");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.hit) |-> (rsp_q.status == iordt_pkg::STS_OK
			&& rsp_q.mapping_id == 32'd0))
		else $error("hit word with bad status or id");

endmodule
